// File: design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// wsdf_pkg
// Types and codes shared by the websocket frame deframer and its checker.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_TEXT   = 2'd1;
  localparam logic [1:0] KIND_BINARY = 2'd2;
  localparam logic [1:0] KIND_CLOSE  = 2'd3;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_MASK   = 2'd1;
  localparam logic [1:0] ERR_LENGTH = 2'd2;
  localparam logic [1:0] ERR_OPCODE = 2'd3;

  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXTLEN  = 6'b000100,
    PH_MASK    = 6'b001000,
    PH_PAYLOAD = 6'b010000,
    PH_DROP    = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_present;
    logic [1:0] message_kind;
    logic       message_end;
    logic [1:0] error_code;
  } result_t;

endpackage

// File: design/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Client-to-server frame parser: header decode, unmasking and message tagging.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one received byte per item (in_rx_byte).
//   out_valid/out_ready carry one result item: an unmasked payload byte with
//   its message kind, an end marker for an empty final frame, or an error.
//   Header bytes give no result, except the last key byte of an empty final
//   frame and a byte that raises an error.
// Timing:
//   one byte is taken every cycle while in_ready is high; its result is
//   registered in the output register or, while one waits, the skid register.
//   The rate is set by the header/payload update and the one-byte key XOR.
// Stall:
//   a two-entry output buffer (output register plus skid register) keeps
//   in_ready high for one more item while a result waits; in_ready drops only
//   when both entries are full.
// Reset:
//   rst_n low returns the parser to the first header byte, clears the message
//   kind and empties the output buffer. After an error all bytes are taken and
//   dropped until reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int LENGTH_BITS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic       out_byte_present,
  output logic [1:0] out_message_kind,
  output logic       out_message_end,
  output logic [1:0] out_error_code
);

  wsdf_pkg::phase_t  phase_r, phase_nxt;
  logic              fin_r, fin_nxt;
  logic [3:0]        opcode_r, opcode_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic [3:0]        cnt_r, cnt_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [31:0]       key_r, key_nxt;
  logic [1:0]        kidx_r, kidx_nxt;

  wsdf_pkg::result_t res;
  logic              res_valid;
  logic              accept;
  logic [7:0]        key_byte;
  logic [1:0]        new_kind;
  logic              op_ok;

  wsdf_pkg::result_t out_r, skid_r;
  logic              out_valid_r, skid_valid_r;
  logic              pop;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  always_comb begin
    case (kidx_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  always_comb begin
    op_ok    = 1'b1;
    new_kind = kind_r;
    case (opcode_r)
      wsdf_pkg::OP_CONT:   new_kind = kind_r;
      wsdf_pkg::OP_TEXT:   new_kind = wsdf_pkg::KIND_TEXT;
      wsdf_pkg::OP_BINARY: new_kind = wsdf_pkg::KIND_BINARY;
      wsdf_pkg::OP_CLOSE:  new_kind = wsdf_pkg::KIND_CLOSE;
      default:             op_ok = 1'b0;
    endcase
  end

  always_comb begin
    phase_nxt  = phase_r;
    fin_nxt    = fin_r;
    opcode_nxt = opcode_r;
    kind_nxt   = kind_r;
    cnt_nxt    = cnt_r;
    len_nxt    = len_r;
    key_nxt    = key_r;
    kidx_nxt   = kidx_r;
    res_valid  = 1'b0;
    res        = '0;
    if (accept) begin
      case (phase_r)
        wsdf_pkg::PH_HDR0: begin
          fin_nxt    = in_rx_byte[7];
          opcode_nxt = in_rx_byte[3:0];
          phase_nxt  = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          if (!in_rx_byte[7]) begin
            phase_nxt      = wsdf_pkg::PH_DROP;
            res_valid      = 1'b1;
            res.error_code = wsdf_pkg::ERR_MASK;
          end else if (in_rx_byte[6:0] == wsdf_pkg::LEN7_EXT16) begin
            len_nxt   = '0;
            cnt_nxt   = wsdf_pkg::EXT16_BYTES;
            phase_nxt = wsdf_pkg::PH_EXTLEN;
          end else if (in_rx_byte[6:0] == wsdf_pkg::LEN7_EXT64) begin
            len_nxt   = '0;
            cnt_nxt   = wsdf_pkg::EXT64_BYTES;
            phase_nxt = wsdf_pkg::PH_EXTLEN;
          end else begin
            len_nxt   = LENGTH_BITS'(in_rx_byte[6:0]);
            cnt_nxt   = wsdf_pkg::KEY_BYTES;
            phase_nxt = wsdf_pkg::PH_MASK;
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          if (len_r[LENGTH_BITS-1 -: 8] != 8'd0) begin
            phase_nxt      = wsdf_pkg::PH_DROP;
            res_valid      = 1'b1;
            res.error_code = wsdf_pkg::ERR_LENGTH;
          end else begin
            len_nxt = {len_r[LENGTH_BITS-9:0], in_rx_byte};
            if (cnt_r == 4'd1) begin
              cnt_nxt   = wsdf_pkg::KEY_BYTES;
              phase_nxt = wsdf_pkg::PH_MASK;
            end else begin
              cnt_nxt = cnt_r - 4'd1;
            end
          end
        end
        wsdf_pkg::PH_MASK: begin
          key_nxt = {key_r[23:0], in_rx_byte};
          if (cnt_r != 4'd1) begin
            cnt_nxt = cnt_r - 4'd1;
          end else if (!op_ok) begin
            cnt_nxt        = 4'd0;
            phase_nxt      = wsdf_pkg::PH_DROP;
            res_valid      = 1'b1;
            res.error_code = wsdf_pkg::ERR_OPCODE;
          end else begin
            cnt_nxt  = 4'd0;
            kidx_nxt = 2'd0;
            kind_nxt = new_kind;
            if (len_r != '0) begin
              phase_nxt = wsdf_pkg::PH_PAYLOAD;
            end else begin
              phase_nxt = wsdf_pkg::PH_HDR0;
              if (fin_r) begin
                kind_nxt         = wsdf_pkg::KIND_NONE;
                res_valid        = 1'b1;
                res.message_kind = new_kind;
                res.message_end  = 1'b1;
              end
            end
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          res_valid        = 1'b1;
          res.payload_byte = in_rx_byte ^ key_byte;
          res.byte_present = 1'b1;
          res.message_kind = kind_r;
          kidx_nxt         = kidx_r + 2'd1;
          len_nxt          = len_r - LENGTH_BITS'(1);
          if (len_r == LENGTH_BITS'(1)) begin
            phase_nxt = wsdf_pkg::PH_HDR0;
            if (fin_r) begin
              res.message_end = 1'b1;
              kind_nxt        = wsdf_pkg::KIND_NONE;
            end
          end
        end
        wsdf_pkg::PH_DROP: begin
          phase_nxt = wsdf_pkg::PH_DROP;
        end
        default: begin
          phase_nxt = wsdf_pkg::PH_HDR0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsdf_pkg::PH_HDR0;
      kind_r  <= wsdf_pkg::KIND_NONE;
      cnt_r   <= 4'd0;
      kidx_r  <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
      kidx_r  <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r    <= fin_nxt;
    opcode_r <= opcode_nxt;
    len_r    <= len_nxt;
    key_r    <= key_nxt;
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else begin
        out_r <= res;
      end
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_byte_present = out_r.byte_present;
  assign out_message_kind = out_r.message_kind;
  assign out_message_end  = out_r.message_end;
  assign out_error_code   = out_r.error_code;

endmodule

// File: design/wsdf_checker.sv
// ----------------------------------------------------------------------------
// wsdf_checker
// Port-level checks on the result channel of the websocket frame deframer.
// ----------------------------------------------------------------------------
module wsdf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic       out_byte_present,
  input logic [1:0] out_message_kind,
  input logic       out_message_end,
  input logic [1:0] out_error_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) &&
    $stable(out_byte_present) && $stable(out_message_kind) &&
    $stable(out_message_end) && $stable(out_error_code))
    else $error("result item changed while stalled");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != wsdf_pkg::ERR_NONE |->
    !out_byte_present && !out_message_end &&
    out_message_kind == wsdf_pkg::KIND_NONE && out_payload_byte == 8'd0)
    else $error("error item carries data");

  a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_present && out_error_code == wsdf_pkg::ERR_NONE |->
    out_message_end && out_payload_byte == 8'd0)
    else $error("marker item without message end");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_error_code != wsdf_pkg::ERR_NONE |=> !out_valid)
    else $error("item after error");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives a byte stream of masked client frames into websocket_frame_deframer
// and checks every result item against a cycle-free model of the parser.
// Directed frames come first, then random messages (fragmented, empty,
// extended lengths, stray continuations) with random idling on both sides,
// and the run closes with one randomly chosen error and dropped bytes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LENGTH_BITS = 32;
  localparam logic [39:0] LEN_LIMIT = (40'd1 << LENGTH_BITS) - 40'd1;
  localparam int ITEM_TARGET = 1750;
  localparam int TAIL_ITEMS = 150;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DROPPED_BYTES = 20;

  typedef enum {FORM_SHORT, FORM_EXT16, FORM_EXT64} len_form_t;

  class frame_tracker;
    wsdf_pkg::phase_t  phase;
    bit                fin_bit;
    logic [3:0]        opcode;
    logic [1:0]        kind;
    logic [3:0]        bytes_left;
    logic [31:0]       frame_len;
    logic [31:0]       key;
    logic [31:0]       index;
    wsdf_pkg::result_t owed[$];
    int                mismatch_count;
    int                results_seen;

    function new();
      phase = wsdf_pkg::PH_HDR0;
      fin_bit = 1'b0;
      opcode = wsdf_pkg::OP_CONT;
      kind = wsdf_pkg::KIND_NONE;
      bytes_left = '0;
      frame_len = '0;
      key = '0;
      index = '0;
      mismatch_count = 0;
      results_seen = 0;
    endfunction

    function int owed_count();
      return owed.size();
    endfunction

    function void raise_error(logic [1:0] code);
      wsdf_pkg::result_t r;
      r = '0;
      r.error_code = code;
      phase = wsdf_pkg::PH_DROP;
      owed.push_back(r);
    endfunction

    function void absorb_byte(logic [7:0] b);
      wsdf_pkg::result_t r;
      logic [39:0] grown;
      logic [7:0] key_byte;
      bit bad_op;
      r = '0;
      bad_op = 1'b0;
      case (phase)
        wsdf_pkg::PH_HDR0: begin
          fin_bit = b[7];
          opcode = b[3:0];
          phase = wsdf_pkg::PH_HDR1;
        end
        wsdf_pkg::PH_HDR1: begin
          if (!b[7]) begin
            raise_error(wsdf_pkg::ERR_MASK);
          end else begin
            frame_len = '0;
            key = '0;
            if (b[6:0] == wsdf_pkg::LEN7_EXT16) begin
              bytes_left = wsdf_pkg::EXT16_BYTES;
              phase = wsdf_pkg::PH_EXTLEN;
            end else if (b[6:0] == wsdf_pkg::LEN7_EXT64) begin
              bytes_left = wsdf_pkg::EXT64_BYTES;
              phase = wsdf_pkg::PH_EXTLEN;
            end else begin
              frame_len = {25'd0, b[6:0]};
              bytes_left = wsdf_pkg::KEY_BYTES;
              phase = wsdf_pkg::PH_MASK;
            end
          end
        end
        wsdf_pkg::PH_EXTLEN: begin
          grown = {frame_len, b};
          if (grown > LEN_LIMIT) begin
            raise_error(wsdf_pkg::ERR_LENGTH);
          end else begin
            frame_len = grown[31:0];
            bytes_left = bytes_left - 4'd1;
            if (bytes_left == 4'd0) begin
              bytes_left = wsdf_pkg::KEY_BYTES;
              phase = wsdf_pkg::PH_MASK;
            end
          end
        end
        wsdf_pkg::PH_MASK: begin
          key = {key[23:0], b};
          bytes_left = bytes_left - 4'd1;
          if (bytes_left == 4'd0) begin
            case (opcode)
              wsdf_pkg::OP_CONT: ;
              wsdf_pkg::OP_TEXT: kind = wsdf_pkg::KIND_TEXT;
              wsdf_pkg::OP_BINARY: kind = wsdf_pkg::KIND_BINARY;
              wsdf_pkg::OP_CLOSE: kind = wsdf_pkg::KIND_CLOSE;
              default: bad_op = 1'b1;
            endcase
            if (bad_op) begin
              raise_error(wsdf_pkg::ERR_OPCODE);
            end else begin
              index = '0;
              if (frame_len != 0) begin
                phase = wsdf_pkg::PH_PAYLOAD;
              end else begin
                phase = wsdf_pkg::PH_HDR0;
                if (fin_bit) begin
                  r.message_kind = kind;
                  r.message_end = 1'b1;
                  kind = wsdf_pkg::KIND_NONE;
                  owed.push_back(r);
                end
              end
            end
          end
        end
        wsdf_pkg::PH_PAYLOAD: begin
          key_byte = 8'(key >> (8 * (3 - index[1:0])));
          r.payload_byte = b ^ key_byte;
          r.byte_present = 1'b1;
          r.message_kind = kind;
          index = index + 1;
          if (index >= frame_len) begin
            phase = wsdf_pkg::PH_HDR0;
            if (fin_bit) begin
              r.message_end = 1'b1;
              kind = wsdf_pkg::KIND_NONE;
            end
          end
          owed.push_back(r);
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_field(string name, int got, int want);
      if (got != want) begin
        flag_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
      end
    endtask

    task match_result(wsdf_pkg::result_t got);
      wsdf_pkg::result_t want;
      if (owed.size() == 0) begin
        flag_mismatch($sformatf("result %0d arrived with nothing outstanding",
                                results_seen));
      end else begin
        want = owed.pop_front();
        check_field("payload_byte", int'(got.payload_byte), int'(want.payload_byte));
        check_field("byte_present", int'(got.byte_present), int'(want.byte_present));
        check_field("message_kind", int'(got.message_kind), int'(want.message_kind));
        check_field("message_end", int'(got.message_end), int'(want.message_end));
        check_field("error_code", int'(got.error_code), int'(want.error_code));
      end
      results_seen++;
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic       out_byte_present;
  logic [1:0] out_message_kind;
  logic       out_message_end;
  logic [1:0] out_error_code;

  frame_tracker      tracker;
  wsdf_pkg::result_t seen;
  int                sent;
  int                quiet_cycles;
  int                stall_left;
  bit                idle_on;
  bit                stall_on;
  int                pick;
  int                frames;
  logic [1:0]        err_sel;
  logic [3:0]        bad_op;
  int                nonzero_pos;

  websocket_frame_deframer #(
    .LENGTH_BITS(LENGTH_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload_byte(out_payload_byte),
    .out_byte_present(out_byte_present),
    .out_message_kind(out_message_kind),
    .out_message_end(out_message_end),
    .out_error_code(out_error_code)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls
  initial begin
    out_ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 99) < 20) begin
        out_ready = 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        tracker.absorb_byte(in_rx_byte);
      end
      if (out_valid && out_ready) begin
        seen.payload_byte = out_payload_byte;
        seen.byte_present = out_byte_present;
        seen.message_kind = out_message_kind;
        seen.message_end = out_message_end;
        seen.error_code = out_error_code;
        tracker.match_result(seen);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_rx_byte = b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_results();
    while (tracker.owed_count() != 0) @(negedge clk);
  endtask

  task automatic send_header(input bit fin, input logic [3:0] op);
    logic [2:0] rsv;
    rsv = 3'($urandom);
    push_byte({fin, rsv, op});
  endtask

  // fill below zero means random payload bytes
  task automatic send_frame(input bit fin, input logic [3:0] op, input len_form_t form,
                            input logic [31:0] len, input logic [31:0] key, input int fill);
    logic [7:0] v;
    send_header(fin, op);
    case (form)
      FORM_SHORT: push_byte({1'b1, len[6:0]});
      FORM_EXT16: begin
        push_byte({1'b1, wsdf_pkg::LEN7_EXT16});
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
      default: begin
        push_byte({1'b1, wsdf_pkg::LEN7_EXT64});
        repeat (4) push_byte(8'h00);
        push_byte(len[31:24]);
        push_byte(len[23:16]);
        push_byte(len[15:8]);
        push_byte(len[7:0]);
      end
    endcase
    push_byte(key[31:24]);
    push_byte(key[23:16]);
    push_byte(key[15:8]);
    push_byte(key[7:0]);
    for (int i = 0; i < len; i++) begin
      v = 8'($urandom);
      if (fill >= 0) v = fill[7:0];
      push_byte(v);
    end
  endtask

  task automatic send_random_frame(input bit fin, input logic [3:0] op);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      send_frame(fin, op, FORM_SHORT, $urandom_range(0, 12), $urandom, -1);
    end else if (roll < 78) begin
      send_frame(fin, op, FORM_SHORT, $urandom_range(13, 125), $urandom, -1);
    end else if (roll < 92) begin
      send_frame(fin, op, FORM_EXT16, $urandom_range(0, 200), $urandom, -1);
    end else begin
      send_frame(fin, op, FORM_EXT64, $urandom_range(0, 40), $urandom, -1);
    end
  endtask

  function automatic logic [3:0] start_op();
    case ($urandom_range(0, 2))
      0: return wsdf_pkg::OP_TEXT;
      1: return wsdf_pkg::OP_BINARY;
      default: return wsdf_pkg::OP_CLOSE;
    endcase
  endfunction

  task automatic send_random_message();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
        send_random_frame(f == frames - 1, (f == 0) ? start_op() : wsdf_pkg::OP_CONT);
      end
    end else if (pick < 90) begin
      // continuation on its own; no message is open unless an unfinished one was left
      send_random_frame(1'($urandom_range(0, 1)), wsdf_pkg::OP_CONT);
    end else begin
      // unfinished message, the next start replaces its kind
      send_random_frame(1'b0, start_op());
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    idle_on = 1'b1;
    stall_on = 1'b1;
    sent = 0;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_frame(1'b0, wsdf_pkg::OP_TEXT, FORM_SHORT, 2, 32'h0000_0000, 8'hff);
    send_frame(1'b1, wsdf_pkg::OP_CONT, FORM_SHORT, 0, $urandom, -1);
    send_frame(1'b1, wsdf_pkg::OP_CLOSE, FORM_EXT16, 1, 32'hffff_ffff, 8'hff);
    send_frame(1'b1, wsdf_pkg::OP_CONT, FORM_SHORT, 1, $urandom, 8'h00);
    drain_results();

    while (sent < ITEM_TARGET - TAIL_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      stall_on = $urandom_range(0, 3) != 0;
      send_random_message();
      if ($urandom_range(0, 9) == 0) drain_results();
    end

    idle_on = 1'b0;
    stall_on = 1'b0;
    while (sent < ITEM_TARGET - 40) send_random_message();

    err_sel = 2'($urandom_range(wsdf_pkg::ERR_MASK, wsdf_pkg::ERR_OPCODE));
    case (err_sel)
      wsdf_pkg::ERR_MASK: begin
        send_header(1'($urandom_range(0, 1)), start_op());
        push_byte({1'b0, 7'($urandom)});
      end
      wsdf_pkg::ERR_LENGTH: begin
        send_header(1'($urandom_range(0, 1)), start_op());
        push_byte({1'b1, wsdf_pkg::LEN7_EXT64});
        nonzero_pos = $urandom_range(0, 3);
        for (int i = 0; i < 8; i++) begin
          if (i < nonzero_pos) push_byte(8'h00);
          else if (i == nonzero_pos) push_byte(8'($urandom_range(1, 255)));
          else push_byte(8'($urandom));
        end
      end
      default: begin
        do bad_op = 4'($urandom);
        while (bad_op == wsdf_pkg::OP_CONT || bad_op == wsdf_pkg::OP_TEXT ||
               bad_op == wsdf_pkg::OP_BINARY || bad_op == wsdf_pkg::OP_CLOSE);
        send_frame(1'($urandom_range(0, 1)), bad_op, FORM_SHORT, $urandom_range(0, 125),
                   $urandom, -1);
      end
    endcase
    repeat (DROPPED_BYTES) push_byte(8'($urandom));

    while (tracker.owed_count() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (tracker.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
